[hdl/nbgeu_pkg.sv]
// Shared types and constants for the n-body gravity Euler update core.
`default_nettype none
package nbgeu_pkg;

    localparam int DEFAULT_MAX_BODIES = 512;

    localparam int IDX_W   = 9;
    localparam int POS_W   = 32;
    localparam int VEL_W   = 32;
    localparam int MASS_W  = 24;
    localparam int CNT_W   = 10;
    localparam int SPD_W   = 64;

    localparam int RAD_W   = 66;   // sum of squared distances
    localparam int ROOT_W  = 35;
    localparam int DEN_W   = 105;  // cube of the root
    localparam int NUM_W   = 92;   // m * |D| * 2^35

    localparam logic       REQ_WRITE  = 1'b0;
    localparam logic       REQ_UPDATE = 1'b1;
    localparam logic       CFG_BODY_COUNT = 1'b0;  // register index bit of paddr

    localparam logic [63:0] TERM_MAX = 64'h2000_0000_0000_0000;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [2:0][VEL_W-1:0] vel;
        logic [MASS_W-1:0]     mass;
    } body_row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOADI,
        ST_FETCH,
        ST_DIFF,
        ST_SUMSQ,
        ST_SQRT,
        ST_CUBE,
        ST_DIV,
        ST_ACC,
        ST_FIN,
        ST_SPD,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

[hdl/nbgeu_body_mem.sv]
// Body table: one row per body holding position, velocity and mass.
`default_nettype none
module nbgeu_body_mem
    import nbgeu_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_BODIES
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire body_row_t                wr_row,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output body_row_t                     rd_row
);

    body_row_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[hdl/nbgeu_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module nbgeu_sqrt
    import nbgeu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root,
    output logic                   done
);

    localparam int SH_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [SH_W-1:0]   sh_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign rem_shift = {rem_reg[REM_W-3:0], sh_reg[SH_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg   <= SH_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            sh_reg   <= {sh_reg[SH_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[hdl/nbgeu_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nbgeu_div
    import nbgeu_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quot,
    output logic                  done
);

    localparam int REM_W = DEN_W + 1;

    logic [NUM_W-1:0] n_reg;
    logic [NUM_W-1:0] q_reg;
    logic [REM_W-1:0] rem_reg;
    logic [DEN_W-1:0] d_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg[REM_W-2:0], n_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= num;
            d_reg   <= den;
            q_reg   <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            n_reg   <= {n_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? (rem_shift - {1'b0, d_reg}) : rem_shift;
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[hdl/nbody_gravity_euler_update_core.sv]
// Top level of the n-body gravity Euler update core.
`default_nettype none
// Keeps a table of up to MAX_BODIES bodies (position Q20.12, velocity Q16.16,
// mass Q20.4) in one synchronous memory. A transaction with s_tuser = 0 loads
// one entry. A transaction with s_tuser = 1 advances the named body one tick:
// after reading that body, the block walks entries 0..body_count-1 (capped
// at MAX_BODIES), reads each other entry from the memory, forms the distance
// vector, its squared length, a 35-step bit-serial square root, the cube
// through a shared 35x35 multiplier, and three 92-step dividers running side
// by side. The dividers dominate the work for each contributing body; the
// named body itself is skipped and a coincident body skips the root and the
// division. Then come the velocity and position update, the speed square and
// the write-back. Update results are written back in place, so later
// transactions see them. A result waits in the m_ output register while
// further write transactions are taken; an update finishing with the register
// still full holds until it drains. Indexes at or above MAX_BODIES are dropped
// silently. body_count lies at APB byte address 0.
module nbody_gravity_euler_update_core
    import nbgeu_pkg::*;
#(
    parameter int MAX_BODIES = DEFAULT_MAX_BODIES
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input transactions
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [8:0] body_index, [40:9] load_pos_x, [72:41] load_pos_y, [104:73] load_pos_z,
    // [136:105] load_vel_x, [168:137] load_vel_y, [200:169] load_vel_z,
    // [224:201] load_mass, [231:225] zero
    input  wire logic [231:0] s_tdata,
    // [0] req_type
    input  wire logic         s_tuser,
    // result transactions
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [8:0] out_index, [40:9] new_pos_x, [72:41] new_pos_y, [104:73] new_pos_z,
    // [168:105] speed_squared, [175:169] zero
    output logic      [175:0] m_tdata,
    // [0] coincident_seen
    output logic              m_tuser,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    localparam int AW = $clog2(MAX_BODIES);
    localparam int JW = $clog2(MAX_BODIES + 1);
    localparam int CW = (JW > CNT_W) ? JW : CNT_W;
    localparam logic signed [63:0] ACC_MAX = $signed(TERM_MAX);

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = ~v + 33'd1;
        return v[32] ? n : v;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] n;
        n = ~v + 32'd1;
        return v[31] ? n : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] body_count_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_count_reg <= '0;
        end else if (cfg_wr && paddr[2] == CFG_BODY_COUNT) begin
            body_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_BODY_COUNT) ? 32'(body_count_reg) : 32'd0;

    logic [CW-1:0] n_wide;
    logic [JW-1:0] n_cnt;
    assign n_wide = (CW'(body_count_reg) > CW'(MAX_BODIES)) ? CW'(MAX_BODIES)
                                                            : CW'(body_count_reg);
    assign n_cnt  = JW'(n_wide);

    // ---------------- input decode ----------------
    logic [IDX_W-1:0] in_idx;
    logic             in_ok;
    logic             in_acc;
    body_row_t        in_row;

    assign in_idx = s_tdata[8:0];
    assign in_ok  = CW'(in_idx) < CW'(MAX_BODIES);
    assign in_acc = s_tvalid && s_tready;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            in_row.pos[a] = s_tdata[9 + 32*a +: 32];
            in_row.vel[a] = s_tdata[105 + 32*a +: 32];
        end
        in_row.mass = s_tdata[224:201];
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [IDX_W-1:0]       idx_reg;
    logic signed [31:0]     pi_reg   [3];
    logic signed [31:0]     vi_reg   [3];
    logic [MASS_W-1:0]      mi_reg;
    logic [MASS_W-1:0]      mj_reg;
    logic [JW-1:0]          j_reg;
    logic signed [63:0]     acc_reg  [3];
    logic                   coin_reg;
    logic signed [32:0]     d_reg    [3];
    logic [2:0]             step_reg;
    logic [RAD_W-1:0]       s_reg;
    logic [ROOT_W-1:0]      r_reg;
    logic [ROOT_W-1:0]      r2hi_reg;
    logic [69:0]            denlo_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [NUM_W-1:0]       num_reg  [3];
    logic [69:0]            prod_reg;
    logic signed [31:0]     newv_reg [3];
    logic signed [31:0]     newp_reg [3];
    logic [SPD_W-1:0]       sp_reg;

    logic                   m_tvalid_reg;
    logic [IDX_W-1:0]       o_idx_reg;
    logic [31:0]            o_pos_reg [3];
    logic [SPD_W-1:0]       o_sp_reg;
    logic                   o_coin_reg;

    // ---------------- shared units ----------------
    logic [34:0]   mul_a, mul_b;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    body_row_t     mem_wrow, mem_rrow;
    logic          sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic          div_start;
    logic [2:0]    div_done;
    logic [NUM_W-1:0] div_num [3];
    logic [NUM_W-1:0] div_q   [3];

    logic [RAD_W-1:0] s_sum;
    logic             out_free;
    logic             j_done, j_self;
    body_row_t        wb_row;

    assign s_sum    = s_reg + RAD_W'(prod_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign j_done   = j_reg >= n_cnt;
    assign j_self   = CW'(j_reg) == CW'(idx_reg);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            wb_row.pos[a] = newp_reg[a];
            wb_row.vel[a] = newv_reg[a];
        end
        wb_row.mass = mi_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    nbgeu_body_mem #(.DEPTH(MAX_BODIES)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_row  (mem_wrow),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_row  (mem_rrow)
    );

    nbgeu_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (s_sum),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    assign div_num[0] = num_reg[0];
    assign div_num[1] = num_reg[1];
    assign div_num[2] = {prod_reg[56:0], 35'd0};  // third axis straight off the multiplier

    for (genvar g = 0; g < 3; g++) begin : g_div
        nbgeu_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start),
            .num     (div_num[g]),
            .den     (den_reg),
            .quot    (div_q[g]),
            .done    (div_done[g])
        );
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc && in_ok && s_tuser == REQ_UPDATE) state_next = ST_LOADI;
            ST_LOADI: state_next = ST_FETCH;
            ST_FETCH: begin
                if (j_done)       state_next = ST_FIN;
                else if (!j_self) state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_SUMSQ;
            ST_SUMSQ: begin
                if (step_reg == 3'd3) state_next = (s_sum == '0) ? ST_FETCH : ST_SQRT;
            end
            ST_SQRT:  if (sqrt_done) state_next = ST_CUBE;
            ST_CUBE:  if (step_reg == 3'd6) state_next = ST_DIV;
            ST_DIV:   if (div_done[0]) state_next = ST_ACC;
            ST_ACC:   state_next = ST_FETCH;
            ST_FIN:   state_next = ST_SPD;
            ST_SPD:   if (step_reg == 3'd3) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = AW'(idx_reg);
        mem_wrow   = wb_row;
        mem_re     = 1'b0;
        mem_raddr  = j_reg[AW-1:0];
        mul_a      = '0;
        mul_b      = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mem_waddr = AW'(in_idx);
                mem_wrow  = in_row;
                mem_raddr = AW'(in_idx);
                if (in_acc && in_ok) begin
                    mem_we = (s_tuser == REQ_WRITE);
                    mem_re = (s_tuser == REQ_UPDATE);
                end
            end
            ST_FETCH: mem_re = !j_done && !j_self;
            ST_SUMSQ: begin
                if (step_reg < 3'd3) begin
                    mul_a = 35'(mag33(d_reg[step_reg[1:0]]));
                    mul_b = 35'(mag33(d_reg[step_reg[1:0]]));
                end
                sqrt_start = (step_reg == 3'd3) && (s_sum != '0);
            end
            ST_CUBE: begin
                case (step_reg)
                    3'd0: begin mul_a = r_reg;          mul_b = r_reg; end
                    3'd1: begin mul_a = prod_reg[34:0]; mul_b = r_reg; end
                    3'd2: begin mul_a = r2hi_reg;       mul_b = r_reg; end
                    3'd3: begin mul_a = 35'(mj_reg); mul_b = 35'(mag33(d_reg[0])); end
                    3'd4: begin mul_a = 35'(mj_reg); mul_b = 35'(mag33(d_reg[1])); end
                    3'd5: begin mul_a = 35'(mj_reg); mul_b = 35'(mag33(d_reg[2])); end
                    default: ;
                endcase
                div_start = (step_reg == 3'd6);
            end
            ST_SPD: begin
                if (step_reg < 3'd3) begin
                    mul_a = 35'(mag32(newv_reg[step_reg[1:0]]));
                    mul_b = 35'(mag32(newv_reg[step_reg[1:0]]));
                end
                mem_we = (step_reg == 3'd0);
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                idx_reg <= in_idx;
            end
            ST_LOADI: begin
                for (int a = 0; a < 3; a++) begin
                    pi_reg[a]  <= $signed(mem_rrow.pos[a]);
                    vi_reg[a]  <= $signed(mem_rrow.vel[a]);
                    acc_reg[a] <= '0;
                end
                mi_reg   <= mem_rrow.mass;
                coin_reg <= 1'b0;
                j_reg    <= '0;
            end
            ST_FETCH: begin
                if (!j_done && j_self) j_reg <= j_reg + JW'(1);
            end
            ST_DIFF: begin
                for (int a = 0; a < 3; a++) begin
                    d_reg[a] <= 33'(pi_reg[a]) - 33'($signed(mem_rrow.pos[a]));
                end
                mj_reg   <= mem_rrow.mass;
                step_reg <= '0;
            end
            ST_SUMSQ: begin
                step_reg <= step_reg + 3'd1;
                s_reg    <= (step_reg == 3'd0) ? '0 : s_sum;
                if (step_reg == 3'd3 && s_sum == '0) begin
                    // coincident body: no contribution, just flag it
                    coin_reg <= 1'b1;
                    j_reg    <= j_reg + JW'(1);
                end
            end
            ST_SQRT: begin
                r_reg    <= sqrt_root;
                step_reg <= '0;
            end
            ST_CUBE: begin
                step_reg <= step_reg + 3'd1;
                case (step_reg)
                    3'd1: r2hi_reg  <= prod_reg[69:35];
                    3'd2: denlo_reg <= prod_reg;
                    3'd3: den_reg   <= DEN_W'(denlo_reg) + (DEN_W'(prod_reg) << 35);
                    3'd4: num_reg[0] <= {prod_reg[56:0], 35'd0};
                    3'd5: num_reg[1] <= {prod_reg[56:0], 35'd0};
                    default: ;
                endcase
            end
            ST_ACC: begin
                for (int a = 0; a < 3; a++) begin
                    logic signed [63:0] qs;
                    logic signed [63:0] nx;
                    qs = (div_q[a] > NUM_W'(TERM_MAX)) ? $signed(TERM_MAX)
                                                        : $signed(64'(div_q[a]));
                    if (d_reg[a] > 0)      nx = acc_reg[a] - qs;
                    else if (d_reg[a] < 0) nx = acc_reg[a] + qs;
                    else                   nx = acc_reg[a];
                    if (nx > ACC_MAX)       nx = ACC_MAX;
                    else if (nx < -ACC_MAX) nx = -ACC_MAX;
                    acc_reg[a] <= nx;
                end
                j_reg <= j_reg + JW'(1);
            end
            ST_FIN: begin
                for (int a = 0; a < 3; a++) begin
                    logic signed [31:0] v;
                    v = sat32(66'(vi_reg[a]) + 66'(acc_reg[a]));
                    newv_reg[a] <= v;
                    // arithmetic shift gives the floor of v / 16
                    newp_reg[a] <= sat32(66'(pi_reg[a]) + 66'(v >>> 4));
                end
                step_reg <= '0;
            end
            ST_SPD: begin
                step_reg <= step_reg + 3'd1;
                sp_reg   <= (step_reg == 3'd0) ? '0 : (sp_reg + SPD_W'(prod_reg));
            end
            ST_OUT: begin
                if (out_free) begin
                    o_idx_reg  <= idx_reg;
                    for (int a = 0; a < 3; a++) o_pos_reg[a] <= newp_reg[a];
                    o_sp_reg   <= sp_reg;
                    o_coin_reg <= coin_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, o_sp_reg, o_pos_reg[2], o_pos_reg[1], o_pos_reg[0], o_idx_reg};
    assign m_tuser  = o_coin_reg;

endmodule
`default_nettype wire

[bench/nbody_gravity_euler_update_core_test.sv]
// Self-checking testbench for the n-body gravity Euler update core.
`default_nettype none
module nbody_gravity_euler_update_core_test;
    import nbgeu_pkg::*;

    localparam int  NBODY     = DEFAULT_MAX_BODIES;
    localparam int  STALL_LIM = 250000;  // longer than one full 512-body update
    localparam int  DRAIN_LAT = 40;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] px, py, pz;
        logic [SPD_W-1:0] spd2;
        logic             coin;
    } tick_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [231:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    nbody_gravity_euler_update_core dut (.*);

    always #10 aclk = ~aclk;

    // shadow copy of the body table and the count register
    logic [POS_W-1:0]  sh_pos [NBODY][3];
    logic [VEL_W-1:0]  sh_vel [NBODY][3];
    logic [MASS_W-1:0] sh_mass[NBODY];
    logic [CNT_W-1:0]  sh_count = '0;

    tick_res_t pending_ticks[$];
    int        fails = 0;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;       // no idling on either side while set

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance one body by one tick on the shadow table; returns the result.
    function automatic tick_res_t advance_body(input int i);
        tick_res_t        res;
        longint           p[3], acc[3], d[3], v[3], q;
        logic [63:0]      dm[3], root, cand;
        logic [127:0]     s, sq, den, num, quo;
        int               n, j, a, b;
        n = (sh_count > NBODY) ? NBODY : sh_count;
        res.coin = 1'b0;
        for (a = 0; a < 3; a++) begin
            p[a] = longint'(signed'(sh_pos[i][a]));
            acc[a] = 0;
        end
        for (j = 0; j < n; j++) begin
            if (j == i) continue;
            s = '0;
            for (a = 0; a < 3; a++) begin
                d[a]  = p[a] - longint'(signed'(sh_pos[j][a]));
                dm[a] = (d[a] < 0) ? -d[a] : d[a];
                s     = s + 128'(dm[a]) * 128'(dm[a]);
            end
            if (s == 0) begin
                res.coin = 1'b1;
                continue;
            end
            root = '0;
            for (b = 34; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                sq   = 128'(cand) * 128'(cand);
                if (s >= sq) root = cand;
            end
            den = 128'(root) * 128'(root) * 128'(root);
            for (a = 0; a < 3; a++) begin
                num = (128'(sh_mass[j]) * 128'(dm[a])) << 35;
                quo = num / den;
                q = (quo > 128'(TERM_MAX)) ? longint'(TERM_MAX) : longint'(quo[63:0]);
                if (d[a] > 0) acc[a] -= q;
                else if (d[a] < 0) acc[a] += q;
                if (acc[a] > longint'(TERM_MAX)) acc[a] = longint'(TERM_MAX);
                if (acc[a] < -longint'(TERM_MAX)) acc[a] = -longint'(TERM_MAX);
            end
        end
        res.idx  = IDX_W'(i);
        res.spd2 = '0;
        for (a = 0; a < 3; a++) begin
            v[a] = clamp32(longint'(signed'(sh_vel[i][a])) + acc[a]);
            p[a] = clamp32(p[a] + (v[a] >>> 4));   // floor division by 16
            sh_vel[i][a] = v[a][31:0];
            sh_pos[i][a] = p[a][31:0];
            res.spd2 += 64'(v[a] * v[a]);
        end
        res.px = sh_pos[i][0];
        res.py = sh_pos[i][1];
        res.pz = sh_pos[i][2];
        return res;
    endfunction

    // Result side: random back-pressure and the scoreboard.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        tick_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ticks.size() == 0) begin
                report($sformatf("unexpected result for body %0d", m_tdata[8:0]));
            end else begin
                exp_r = pending_ticks.pop_front();
                if (m_tdata[8:0] !== exp_r.idx)
                    report($sformatf("index %0d, want %0d", m_tdata[8:0], exp_r.idx));
                if (m_tdata[40:9] !== exp_r.px)
                    report($sformatf("body %0d pos x %h, want %h", exp_r.idx,
                                     m_tdata[40:9], exp_r.px));
                if (m_tdata[72:41] !== exp_r.py)
                    report($sformatf("body %0d pos y %h, want %h", exp_r.idx,
                                     m_tdata[72:41], exp_r.py));
                if (m_tdata[104:73] !== exp_r.pz)
                    report($sformatf("body %0d pos z %h, want %h", exp_r.idx,
                                     m_tdata[104:73], exp_r.pz));
                if (m_tdata[168:105] !== exp_r.spd2)
                    report($sformatf("body %0d speed^2 %h, want %h", exp_r.idx,
                                     m_tdata[168:105], exp_r.spd2));
                if (m_tuser !== exp_r.coin)
                    report($sformatf("body %0d coincident flag %b, want %b", exp_r.idx,
                                     m_tuser, exp_r.coin));
            end
        end
    end

    // Watchdog: cycles with no transaction on either stream or the configuration bus.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIM) begin
            $display("TIMEOUT: no transaction for %0d cycles", STALL_LIM);
            $display("nbody_gravity_euler_update_core_test NOT OK");
            $finish;
        end
    end

    // One input transaction. Valid stays high on return so back-to-back items
    // never lower and raise it in the same step.
    task automatic send_item(input logic kind, input int i,
                             input logic [31:0] px, py, pz, vx, vy, vz,
                             input logic [23:0] m);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, m, vz, vy, vx, pz, py, px, 9'(i)};
        do @(posedge aclk); while (!s_tready);
        if (kind == REQ_WRITE) begin
            sh_pos[i][0] = px; sh_pos[i][1] = py; sh_pos[i][2] = pz;
            sh_vel[i][0] = vx; sh_vel[i][1] = vy; sh_vel[i][2] = vz;
            sh_mass[i]   = m;
        end else begin
            pending_ticks.insert(pending_ticks.size(), advance_body(i));
        end
    endtask

    task automatic load_body(input int i, input logic [31:0] px, py, pz, vx, vy, vz,
                             input logic [23:0] m);
        send_item(REQ_WRITE, i, px, py, pz, vx, vy, vz, m);
    endtask

    task automatic tick_body(input int i);
        send_item(REQ_UPDATE, i, '0, '0, '0, '0, '0, '0, '0);
    endtask

    // Lower valid and wait until every result is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_ticks.size() != 0) @(posedge aclk);
    endtask

    // Only while idle: drained, then a wait for any trailing write.
    task automatic set_body_count(input int n);
        drain();
        repeat (DRAIN_LAT) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {CFG_BODY_COUNT, 2'b00};
        pwdata  <= 32'(n);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sh_count = CNT_W'(n);
    endtask

    // Mostly small coordinates so bodies interact strongly; now and then full range.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return 32'($urandom_range(8191)) - 32'd4096;
            default: return 32'($urandom_range(262143)) - 32'd131072;
        endcase
    endfunction

    function automatic logic [23:0] pick_mass();
        case ($urandom_range(4))
            0:       return 24'($urandom());
            1:       return '0;
            default: return 24'($urandom_range(4095));
        endcase
    endfunction

    function automatic int pick_body();
        return ($urandom_range(9) == 0) ? $urandom_range(NBODY - 1) : $urandom_range(7);
    endfunction

    // Every entry is written first, so no update ever reads an unwritten one.
    task automatic test_fill_table();
        calm = 1'b1;
        for (int i = 0; i < NBODY; i++)
            load_body(i, pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(), pick_mass());
        calm = 1'b0;
    endtask

    task automatic test_directed();
        set_body_count(4);
        // field extremes
        load_body(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
        load_body(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
        // coincident pair, one of them massless
        load_body(2, 32'h0000_1000, 32'hFFFF_F000, 32'h0, 32'h0, 32'h0001_0000,
                  32'hFFFF_0000, 24'h0);
        load_body(3, 32'h0000_1000, 32'hFFFF_F000, 32'h0, 32'h0, 32'h0, 32'h0, 24'h10);
        for (int i = 0; i < 4; i++) tick_body(i);
        tick_body(2);
        // body outside the count still advances
        load_body(511, 32'h0000_2000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0, 24'h1);
        tick_body(511);
        set_body_count(0);
        tick_body(0);
        tick_body(3);
        drain();
    endtask

    // Largest counts: above the table size it clamps to the table size.
    task automatic test_full_count();
        set_body_count(1023);
        tick_body($urandom_range(NBODY - 1));
        set_body_count(NBODY);
        tick_body($urandom_range(NBODY - 1));
        set_body_count(1);
        tick_body(0);
        tick_body(1);
        drain();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 10; ph++) begin
            set_body_count((ph == 9) ? 2 : $urandom_range(6));
            calm = (ph == 4);
            for (int k = 0; k < 13; k++) begin
                if (ph == 6 && k == 6) drain();   // let the pipe run dry mid-stream
                if ($urandom_range(1))
                    load_body(pick_body(), pick_coord(), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), pick_coord(), pick_mass());
                else
                    tick_body(pick_body());
            end
            calm = 1'b0;
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_table();
        test_directed();
        test_full_count();
        test_random_traffic();
        repeat (DRAIN_LAT) @(posedge aclk);
        if (fails == 0 && pending_ticks.size() == 0) begin
            $display("nbody_gravity_euler_update_core_test OK");
        end else begin
            $display("nbody_gravity_euler_update_core_test NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
hdl/nbgeu_pkg.sv
hdl/nbgeu_body_mem.sv
hdl/nbgeu_sqrt.sv
hdl/nbgeu_div.sv
hdl/nbody_gravity_euler_update_core.sv
bench/nbody_gravity_euler_update_core_test.sv
